// ===== rtl/core/fea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_pkg
// Shared types and constants of the free extent allocator.
// ----------------------------------------------------------------------------
package fea_pkg;

  // Table geometry
  localparam int MAX_EXTENTS = 64;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

  // Field widths
  localparam int BLOCK_W  = 32;
  localparam int LEN_W    = BLOCK_W + 1;
  localparam int TOTAL_W  = 33;
  localparam int COUNT_W  = 16;
  localparam int SHIFT_W  = 4;
  localparam int NB_W     = COUNT_W + (1 << SHIFT_W) - 1;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 8;

  // Superpage geometry
  localparam int SP_BLOCKS = 512;
  localparam int SP_W      = $clog2(SP_BLOCKS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 8'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADCOUNT = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERLAP  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_BAD   = 3'd1,
    K_INIT  = 3'd2,
    K_ALLOC = 3'd3,
    K_FREE  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [BLOCK_W-1:0] block;
    logic [NB_W-1:0]    nb;
    logic               carve;
    logic               tail;
    logic               is_log;
  } cmd_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] lo;
    logic [BLOCK_W-1:0] hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [BLOCK_W-1:0] first;
    logic [BLOCK_W-1:0] last;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

endpackage

// ===== rtl/core/free_extent_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_extent_allocator
// First-fit free extent allocator with coalescing for one partition.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (op, block, count, hint_start, search_tail, is_log) enter on
//   the in_valid_i / in_ready_o channel; each gives exactly one result word
//   (status, start_block, units, avail_total) on out_valid_o / out_ready_i.
//   Configuration words (cfg_index_i, cfg_data_i) are always accepted; write
//   them only while no request is in flight.
//   A two-entry queue parts the front end from the execution unit, and the
//   result sits in an output register, so the next request is taken while a
//   stalled result waits.
//   Init, bad counts, range errors and the unused op are decided at dispatch
//   and go straight to the output register. A free walks the extents below
//   the run, an alloc reads the extents it visits in each search pass (two
//   passes when a superpage carve is tried), and an insert or remove moves
//   the table entries above its slot one at a time, through the table's
//   single read port.
//   Reset empties the table, clears the free total and restores the
//   configured range to first = 1, last = 0, unit shift 0.
// ----------------------------------------------------------------------------
module free_extent_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fea_pkg::BLOCK_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fea_pkg::OP_W-1:0]      op_i,
  input  logic [fea_pkg::BLOCK_W-1:0]   block_i,
  input  logic [fea_pkg::COUNT_W-1:0]   count_i,
  input  logic [fea_pkg::BLOCK_W-1:0]   hint_start_i,
  input  logic                          search_tail_i,
  input  logic                          is_log_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fea_pkg::STATUS_W-1:0]  status_o,
  output logic [fea_pkg::BLOCK_W-1:0]   start_block_o,
  output logic [fea_pkg::COUNT_W-1:0]   units_o,
  output logic [fea_pkg::TOTAL_W-1:0]   avail_total_o
);
  import fea_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic [CNT_W-1:0] ext_count;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST: cfg_d.first = cfg_data_i;
        CFG_LAST:  cfg_d.last  = cfg_data_i;
        CFG_SHIFT: cfg_d.shift = cfg_data_i[SHIFT_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{first: BLOCK_W'(1), last: '0, shift: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fea_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .block_i       (block_i),
    .count_i       (count_i),
    .hint_start_i  (hint_start_i),
    .search_tail_i (search_tail_i),
    .is_log_i      (is_log_i),
    .unit_shift_i  (cfg_q.shift),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  fea_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .count_o       (ext_count),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .start_block_o (start_block_o),
    .units_o       (units_o),
    .avail_total_o (avail_total_o)
  );

  // Extent table
  fea_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_count <= CNT_W'(MAX_EXTENTS))
    else $error("extent count beyond table size");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (start_block_o == '0) && (units_o == '0))
    else $error("failed result carries a run");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= STATUS_W'(ST_FULL)))
    else $error("status code out of range");

endmodule

// ===== rtl/core/fea_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fea_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_front
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fea_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fea_pkg::OP_W-1:0]     op_i,
  input  logic [fea_pkg::BLOCK_W-1:0]  block_i,
  input  logic [fea_pkg::COUNT_W-1:0]  count_i,
  input  logic [fea_pkg::BLOCK_W-1:0]  hint_start_i,
  input  logic                         search_tail_i,
  input  logic                         is_log_i,
  input  logic [fea_pkg::SHIFT_W-1:0]  unit_shift_i,
  output logic                         cmd_valid_o,
  output fea_pkg::cmd_t                cmd_o,
  input  logic                         cmd_pop_i
);
  import fea_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              cmd_c;
  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;

  // Classify the request and scale the count to blocks
  always_comb begin
    cmd_c        = '0;
    cmd_c.block  = block_i;
    cmd_c.nb     = NB_W'(count_i) << unit_shift_i;
    cmd_c.tail   = search_tail_i;
    cmd_c.is_log = is_log_i;
    cmd_c.carve  = !is_log_i && (hint_start_i[SP_W-1:0] == '0) &&
                   (cmd_c.nb >= NB_W'(SP_BLOCKS));
    case (op_i)
      OP_INIT:  cmd_c.kind = K_INIT;
      OP_ALLOC: cmd_c.kind = (count_i == '0) ? K_BAD : K_ALLOC;
      OP_FREE:  cmd_c.kind = (count_i == '0) ? K_BAD : K_FREE;
      default:  cmd_c.kind = K_NOP;
    endcase
  end

  // Two-entry command queue
  assign in_ready_o  = (fill_q != QCNT_W'(QDEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_c;
    end
  end

endmodule

// ===== rtl/core/fea_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fea_back
// Executes queued commands on the extent table and registers each result.
// ----------------------------------------------------------------------------
module fea_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fea_pkg::cfg_t                 cfg_i,
  input  logic                          cmd_valid_i,
  input  fea_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          ram_we_o,
  output logic [fea_pkg::IDX_W-1:0]     ram_waddr_o,
  output fea_pkg::entry_t               ram_wdata_o,
  output logic [fea_pkg::IDX_W-1:0]     ram_raddr_o,
  input  fea_pkg::entry_t               ram_rdata_i,
  output logic [fea_pkg::CNT_W-1:0]     count_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fea_pkg::STATUS_W-1:0]  status_o,
  output logic [fea_pkg::BLOCK_W-1:0]   start_block_o,
  output logic [fea_pkg::COUNT_W-1:0]   units_o,
  output logic [fea_pkg::TOTAL_W-1:0]   avail_total_o
);
  import fea_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_FCHK = 4'd3;
  localparam logic [3:0] S_FDEC = 4'd4;
  localparam logic [3:0] S_ARD  = 4'd5;
  localparam logic [3:0] S_ACHK = 4'd6;
  localparam logic [3:0] S_ADEC = 4'd7;
  localparam logic [3:0] S_RMRD = 4'd8;
  localparam logic [3:0] S_RMWR = 4'd9;
  localparam logic [3:0] S_INRD = 4'd10;
  localparam logic [3:0] S_INWR = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  localparam logic [LEN_W-1:0] SP_LEN  = LEN_W'(SP_BLOCKS);
  localparam logic [LEN_W-1:0] SP_MASK = ~(LEN_W'(SP_BLOCKS - 1));

  // Control state
  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;

  // Working registers
  cmd_t               cmd_q, cmd_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   sh_idx_q, sh_idx_d;
  logic               carve_pass_q, carve_pass_d;
  entry_t             prev_q, prev_d, cur_q, cur_d, ent_q, ent_d, ins_q, ins_d;
  logic               prev_v_q, prev_v_d, cur_v_q, cur_v_d;
  logic [LEN_W-1:0]   fhigh_q, fhigh_d;
  logic [LEN_W-1:0]   len_q, len_d, lenlm_q, lenlm_d, avail_q, avail_d;
  logic [SP_W-1:0]    lm_q, lm_d;
  status_e            res_status_q, res_status_d;
  logic [BLOCK_W-1:0] res_start_q, res_start_d;
  logic [COUNT_W-1:0] res_units_q, res_units_d;

  // Output register
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [BLOCK_W-1:0]  out_start_q, out_start_d;
  logic [COUNT_W-1:0]  out_units_q, out_units_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  // Combinational helpers
  logic [CNT_W-1:0]   widx_c;
  logic [LEN_W-1:0]   nb_c, len_c, lenlm_c, n_c, rm_c;
  logic [SP_W-1:0]    lm_c;
  logic [BLOCK_W-1:0] start_c, lolm_c;
  logic               found_c, skip_c, left_c, right_c, ovl_c;

  assign nb_c   = LEN_W'(cmd_q.nb);
  assign widx_c = cmd_q.tail ? (count_q - CNT_W'(1) - k_q) : k_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_d        = cmd_q;
    k_d          = k_q;
    idx_d        = idx_q;
    sh_idx_d     = sh_idx_q;
    carve_pass_d = carve_pass_q;
    prev_d       = prev_q;
    prev_v_d     = prev_v_q;
    cur_d        = cur_q;
    cur_v_d      = cur_v_q;
    ent_d        = ent_q;
    ins_d        = ins_q;
    fhigh_d      = fhigh_q;
    len_d        = len_q;
    lenlm_d      = lenlm_q;
    avail_d      = avail_q;
    lm_d         = lm_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_units_d  = res_units_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_units_d  = out_units_q;
    out_total_d  = out_total_q;
    cmd_pop_o    = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = '0;
    ram_wdata_o  = '0;
    ram_raddr_o  = '0;
    len_c        = '0;
    lenlm_c      = '0;
    lm_c         = '0;
    n_c          = '0;
    rm_c         = '0;
    start_c      = '0;
    lolm_c       = '0;
    found_c      = 1'b0;
    skip_c       = 1'b0;
    left_c       = 1'b0;
    right_c      = 1'b0;
    ovl_c        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_DISP;
        end
      end

      // First decision on the command
      S_DISP: begin
        res_status_d = ST_OK;
        res_start_d  = '0;
        res_units_d  = '0;
        fhigh_d      = LEN_W'(cmd_q.block) + nb_c - LEN_W'(1);
        state_d      = S_EMIT;
        case (cmd_q.kind)
          K_BAD: res_status_d = ST_BADCOUNT;
          K_INIT: begin
            if (cfg_i.last >= cfg_i.first) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = '0;
              ram_wdata_o = '{lo: cfg_i.first, hi: cfg_i.last};
              count_d     = CNT_W'(1);
              total_d     = TOTAL_W'(LEN_W'(cfg_i.last) - LEN_W'(cfg_i.first) + LEN_W'(1));
            end else begin
              count_d      = '0;
              total_d      = '0;
              res_status_d = ST_RANGE;
            end
          end
          K_FREE: begin
            if (cmd_q.block < cfg_i.first || fhigh_d > LEN_W'(cfg_i.last)) begin
              res_status_d = ST_RANGE;
            end else begin
              k_d      = '0;
              prev_v_d = 1'b0;
              state_d  = S_FRD;
            end
          end
          K_ALLOC: begin
            if (count_q == '0 || total_q == '0) begin
              res_status_d = ST_NOSPACE;
            end else if (cmd_q.is_log && total_q < TOTAL_W'(cmd_q.nb)) begin
              res_status_d = ST_NOSPACE;
            end else begin
              carve_pass_d = cmd_q.carve;
              k_d          = '0;
              state_d      = S_ARD;
            end
          end
          default: res_status_d = ST_OK;
        endcase
      end

      // Free: walk to the first extent that does not end below the run
      S_FRD: begin
        if (k_q == count_q) begin
          cur_v_d = 1'b0;
          state_d = S_FDEC;
        end else begin
          ram_raddr_o = k_q[IDX_W-1:0];
          state_d     = S_FCHK;
        end
      end

      S_FCHK: begin
        if (ram_rdata_i.hi < cmd_q.block) begin
          prev_d   = ram_rdata_i;
          prev_v_d = 1'b1;
          k_d      = k_q + CNT_W'(1);
          state_d  = S_FRD;
        end else begin
          cur_d   = ram_rdata_i;
          cur_v_d = 1'b1;
          state_d = S_FDEC;
        end
      end

      // Free: overlap check, then merge with the neighbors or insert a new entry
      S_FDEC: begin
        ovl_c   = cur_v_q && (LEN_W'(cur_q.lo) <= fhigh_q);
        left_c  = prev_v_q && (LEN_W'(prev_q.hi) + LEN_W'(1) == LEN_W'(cmd_q.block));
        right_c = cur_v_q && (fhigh_q + LEN_W'(1) == LEN_W'(cur_q.lo));
        state_d = S_EMIT;
        if (ovl_c) begin
          res_status_d = ST_OVERLAP;
        end else if (left_c && right_c) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = IDX_W'(k_q - CNT_W'(1));
          ram_wdata_o = '{lo: prev_q.lo, hi: cur_q.hi};
          total_d     = total_q + TOTAL_W'(cmd_q.nb);
          state_d     = S_RMRD;
        end else if (left_c) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = IDX_W'(k_q - CNT_W'(1));
          ram_wdata_o = '{lo: prev_q.lo, hi: fhigh_q[BLOCK_W-1:0]};
          total_d     = total_q + TOTAL_W'(cmd_q.nb);
        end else if (right_c) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = k_q[IDX_W-1:0];
          ram_wdata_o = '{lo: cmd_q.block, hi: cur_q.hi};
          total_d     = total_q + TOTAL_W'(cmd_q.nb);
        end else if (count_q >= CNT_W'(MAX_EXTENTS)) begin
          res_status_d = ST_FULL;
        end else begin
          ins_d    = '{lo: cmd_q.block, hi: fhigh_q[BLOCK_W-1:0]};
          sh_idx_d = k_q;
          k_d      = count_q;
          total_d  = total_q + TOTAL_W'(cmd_q.nb);
          state_d  = S_INRD;
        end
      end

      // Alloc: fetch the next extent in search order
      S_ARD: begin
        if (k_q == count_q) begin
          if (carve_pass_q) begin
            carve_pass_d = 1'b0;
            k_d          = '0;
          end else begin
            res_status_d = ST_NOSPACE;
            state_d      = S_EMIT;
          end
        end else begin
          ram_raddr_o = widx_c[IDX_W-1:0];
          idx_d       = widx_c;
          state_d     = S_ACHK;
        end
      end

      // Alloc: extent length and superpage room
      S_ACHK: begin
        len_c   = LEN_W'(ram_rdata_i.hi) - LEN_W'(ram_rdata_i.lo) + LEN_W'(1);
        lm_c    = SP_W'(~ram_rdata_i.lo[SP_W-1:0]) + SP_W'(1);
        lenlm_c = len_c - LEN_W'(lm_c);
        ent_d   = ram_rdata_i;
        len_d   = len_c;
        lm_d    = lm_c;
        lenlm_d = lenlm_c;
        if (len_c < SP_LEN || len_c <= LEN_W'(lm_c) || lenlm_c < SP_LEN) begin
          avail_d = '0;
        end else begin
          avail_d = lenlm_c & SP_MASK;
        end
        state_d = S_ADEC;
      end

      // Alloc: take the extent, a slice of it, or move on
      S_ADEC: begin
        state_d = S_EMIT;
        if (carve_pass_q) begin
          n_c    = (nb_c > avail_q) ? avail_q : nb_c;
          rm_c   = lenlm_q - n_c;
          lolm_c = ent_q.lo + BLOCK_W'(lm_q);
          if (avail_q == '0) begin
            skip_c = 1'b1;
          end else if (lm_q != '0 && rm_c != '0 && count_q >= CNT_W'(MAX_EXTENTS)) begin
            // split impossible: fall back to plain first fit
            carve_pass_d = 1'b0;
            k_d          = '0;
            state_d      = S_ARD;
          end else begin
            found_c = 1'b1;
            start_c = lolm_c;
            if (lm_q != '0) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = idx_q[IDX_W-1:0];
              ram_wdata_o = '{lo: ent_q.lo, hi: lolm_c - BLOCK_W'(1)};
              if (rm_c != '0) begin
                ins_d    = '{lo: BLOCK_W'(LEN_W'(lolm_c) + n_c), hi: ent_q.hi};
                sh_idx_d = idx_q + CNT_W'(1);
                k_d      = count_q;
                state_d  = S_INRD;
              end
            end else if (rm_c != '0) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = idx_q[IDX_W-1:0];
              ram_wdata_o = '{lo: BLOCK_W'(LEN_W'(ent_q.lo) + n_c), hi: ent_q.hi};
            end else begin
              k_d     = idx_q;
              state_d = S_RMRD;
            end
          end
        end else begin
          if (nb_c >= len_q) begin
            if (cfg_i.shift != '0 && nb_c > len_q) begin
              skip_c = 1'b1;
            end else begin
              found_c = 1'b1;
              start_c = ent_q.lo;
              n_c     = len_q;
              k_d     = idx_q;
              state_d = S_RMRD;
            end
          end else if (!cmd_q.tail) begin
            found_c     = 1'b1;
            start_c     = ent_q.lo;
            n_c         = nb_c;
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_q[IDX_W-1:0];
            ram_wdata_o = '{lo: ent_q.lo + BLOCK_W'(cmd_q.nb), hi: ent_q.hi};
          end else begin
            found_c     = 1'b1;
            start_c     = BLOCK_W'(LEN_W'(ent_q.hi) + LEN_W'(1) - nb_c);
            n_c         = nb_c;
            ram_we_o    = 1'b1;
            ram_waddr_o = idx_q[IDX_W-1:0];
            ram_wdata_o = '{lo: ent_q.lo, hi: ent_q.hi - BLOCK_W'(cmd_q.nb)};
          end
        end
        if (skip_c) begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_ARD;
        end
        // Settle status and free total once a run is chosen
        if (found_c) begin
          if (total_q < TOTAL_W'(n_c)) begin
            res_status_d = ST_NOSPACE;
          end else begin
            total_d = total_q - TOTAL_W'(n_c);
            if (start_c == '0) begin
              res_status_d = ST_NOSPACE;
            end else begin
              res_start_d = start_c;
              res_units_d = COUNT_W'(n_c >> cfg_i.shift);
            end
          end
        end
      end

      // Remove entry k: pull the tail of the table down by one
      S_RMRD: begin
        if (k_q + CNT_W'(1) < count_q) begin
          ram_raddr_o = IDX_W'(k_q + CNT_W'(1));
          state_d     = S_RMWR;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_EMIT;
        end
      end

      S_RMWR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = k_q[IDX_W-1:0];
        ram_wdata_o = ram_rdata_i;
        k_d         = k_q + CNT_W'(1);
        state_d     = S_RMRD;
      end

      // Insert at sh_idx: push the tail of the table up by one
      S_INRD: begin
        if (k_q > sh_idx_q) begin
          ram_raddr_o = IDX_W'(k_q - CNT_W'(1));
          state_d     = S_INWR;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = sh_idx_q[IDX_W-1:0];
          ram_wdata_o = ins_q;
          count_d     = count_q + CNT_W'(1);
          state_d     = S_EMIT;
        end
      end

      S_INWR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = k_q[IDX_W-1:0];
        ram_wdata_o = ram_rdata_i;
        k_d         = k_q - CNT_W'(1);
        state_d     = S_INRD;
      end

      // Hand the result to the output register
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = (res_status_q == ST_OK) ? res_start_q : '0;
          out_units_d  = (res_status_q == ST_OK) ? res_units_q : '0;
          out_total_d  = total_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    k_q          <= k_d;
    idx_q        <= idx_d;
    sh_idx_q     <= sh_idx_d;
    carve_pass_q <= carve_pass_d;
    prev_q       <= prev_d;
    prev_v_q     <= prev_v_d;
    cur_q        <= cur_d;
    cur_v_q      <= cur_v_d;
    ent_q        <= ent_d;
    ins_q        <= ins_d;
    fhigh_q      <= fhigh_d;
    len_q        <= len_d;
    lenlm_q      <= lenlm_d;
    avail_q      <= avail_d;
    lm_q         <= lm_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_units_q  <= res_units_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_units_q  <= out_units_d;
    out_total_q  <= out_total_d;
  end

  assign count_o       = count_q;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign start_block_o = out_start_q;
  assign units_o       = out_units_q;
  assign avail_total_o = out_total_q;

endmodule
